// ----- src/dmwbc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Shared types and constants for the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_WB,
      ST_FILL,
      ST_ACCESS,
      ST_DONE
   } state_type;

   typedef struct packed {
      state_type state;
      logic      cache_we;
      logic      mem_we;
      logic      load_rsp;
   } ctl_type;

endpackage

// ----- src/dmwbc_ram.sv -----
// ----------------------------------------------------------------------------
// dmwbc_ram
// Single-port RAM, one read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module dmwbc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/dmwbc_seq.sv -----
// ----------------------------------------------------------------------------
// dmwbc_seq
// Access sequencer: tag lookup, byte-serial write-back and fill through one
// stepping byte counter, final byte access, and the post-reset clearing pass.
// ----------------------------------------------------------------------------
module dmwbc_seq
   import dmwbc_pkg::*;
#(
   parameter int LINE_BYTES   = 8,
   parameter int LINE_COUNT   = 32,
   parameter int MEMORY_BYTES = 65536,
   parameter int OFF_W        = $clog2(LINE_BYTES),
   parameter int LINE_W       = $clog2(LINE_COUNT),
   parameter int CA_W         = OFF_W + LINE_W,
   parameter int MEM_W        = $clog2(MEMORY_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_wdata,
   input  logic              out_free,
   input  logic [DATA_W-1:0] cache_rdata,
   input  logic [DATA_W-1:0] mem_rdata,
   output ctl_type           ctl,
   output logic [CA_W-1:0]   cache_addr,
   output logic [DATA_W-1:0] cache_wdata,
   output logic [MEM_W-1:0]  main_addr,
   output logic [DATA_W-1:0] mem_wdata,
   output logic              rd_hit,
   output logic              rd_dirty
);

   localparam int TAG_BITS  = ADDR_W - OFF_W - LINE_W;
   localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
   localparam int CACHE_SZ  = LINE_COUNT * LINE_BYTES;
   localparam int CLR_DEPTH = (MEMORY_BYTES > CACHE_SZ) ? MEMORY_BYTES : CACHE_SZ;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int FULL_W    = TAG_W + LINE_W + OFF_W;
   localparam int WIDE_W    = (FULL_W > MEM_W) ? FULL_W : MEM_W;

   state_type          state_ff, state_in;
   logic [CLR_W-1:0]   cnt_ff, cnt_in;
   logic               kind_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [LINE_W-1:0]  line_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [DATA_W-1:0]  wdata_ff;
   logic [TAG_W-1:0]   old_tag_ff;
   logic               hit_ff;
   logic               was_dirty_ff;
   logic [TAG_W-1:0]   tags_ff [LINE_COUNT];
   logic [LINE_COUNT-1:0] dirty_ff;

   logic [ADDR_W-1:0]  addr_sh;
   logic               hit_now;
   logic               dirty_now;
   logic               clr_end;
   logic               xfer_end;
   logic [OFF_W-1:0]   cnt_off;
   logic [OFF_W-1:0]   cnt_off_m1;
   logic [WIDE_W-1:0]  wb_wide;
   logic [WIDE_W-1:0]  fill_wide;
   logic               fill_done;
   logic               mark_dirty;
   logic               accept;

   assign addr_sh    = req_address >> (OFF_W + LINE_W);
   assign hit_now    = (tags_ff[line_ff] == tag_ff);
   assign dirty_now  = dirty_ff[line_ff];
   assign clr_end    = (cnt_ff == CLR_W'(CLR_DEPTH - 1));
   assign xfer_end   = (cnt_ff == CLR_W'(LINE_BYTES));
   assign cnt_off    = cnt_ff[OFF_W-1:0];
   assign cnt_off_m1 = cnt_off - OFF_W'(1);
   assign wb_wide    = WIDE_W'({old_tag_ff, line_ff, cnt_off_m1});
   assign fill_wide  = WIDE_W'({tag_ff, line_ff, cnt_off});
   assign accept     = req_valid && req_ready;
   assign fill_done  = (state_ff == ST_FILL) && xfer_end;
   assign mark_dirty = (state_ff == ST_ACCESS) && (kind_ff == KIND_WRITE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_end) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP: begin
            if (hit_now) state_in = ST_ACCESS;
            else if (dirty_now) state_in = ST_WB;
            else state_in = ST_FILL;
         end
         ST_WB:     if (xfer_end) state_in = ST_FILL;
         ST_FILL:   if (xfer_end) state_in = ST_ACCESS;
         ST_ACCESS: begin
            if (kind_ff == KIND_WRITE) state_in = ST_IDLE;
            else state_in = ST_DONE;
         end
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = '0;
      case (state_ff)
         ST_CLEAR: cnt_in = cnt_ff + CLR_W'(1);
         ST_WB:    cnt_in = xfer_end ? '0 : cnt_ff + CLR_W'(1);
         ST_FILL:  cnt_in = cnt_ff + CLR_W'(1);
         default:  cnt_in = '0;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      ctl.state    = state_ff;
      ctl.cache_we = 1'b0;
      ctl.mem_we   = 1'b0;
      ctl.load_rsp = 1'b0;
      cache_addr   = {line_ff, off_ff};
      cache_wdata  = wdata_ff;
      main_addr    = fill_wide[MEM_W-1:0];
      mem_wdata    = cache_rdata;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.cache_we = 1'b1;
            ctl.mem_we   = 1'b1;
            cache_addr   = cnt_ff[CA_W-1:0];
            cache_wdata  = '0;
            main_addr    = cnt_ff[MEM_W-1:0];
            mem_wdata    = '0;
         end
         ST_IDLE:   req_ready = 1'b1;
         ST_LOOKUP: ;
         ST_WB: begin
            cache_addr = {line_ff, cnt_off};
            main_addr  = wb_wide[MEM_W-1:0];
            ctl.mem_we = (cnt_ff != '0);
         end
         ST_FILL: begin
            cache_addr   = {line_ff, cnt_off_m1};
            cache_wdata  = mem_rdata;
            ctl.cache_we = (cnt_ff != '0);
         end
         ST_ACCESS: ctl.cache_we = (kind_ff == KIND_WRITE);
         ST_DONE:   ctl.load_rsp = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < LINE_COUNT; i++) begin
            tags_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (fill_done) begin
            tags_ff[line_ff]  <= tag_ff;
            dirty_ff[line_ff] <= 1'b0;
         end
         if (mark_dirty) begin
            dirty_ff[line_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         tag_ff   <= (TAG_BITS > 0) ? addr_sh[TAG_W-1:0] : '0;
         line_ff  <= req_address[OFF_W +: LINE_W];
         off_ff   <= req_address[OFF_W-1:0];
         wdata_ff <= req_wdata;
      end
      if (state_ff == ST_LOOKUP) begin
         hit_ff       <= hit_now;
         was_dirty_ff <= dirty_now;
         old_tag_ff   <= tags_ff[line_ff];
      end
   end

   assign rd_hit   = hit_ff;
   assign rd_dirty = was_dirty_ff;

endmodule

// ----- src/direct_mapped_writeback_cache.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped write-back cache of LINE_COUNT lines of LINE_BYTES bytes in
// front of a MEMORY_BYTES byte memory, one byte moved per cycle.
//
// req channel: one access word; tuser is the kind (read or write), tdata
// carries address and write byte. rsp channel: one word per read, with the
// cached byte, the hit flag and the dirty mark the line had before access.
// Writes give no rsp word.
// After reset a clearing pass zeroes memory and cache data, one byte a cycle,
// over max(MEMORY_BYTES, LINE_COUNT*LINE_BYTES) byte addresses; req_tready
// stays low meanwhile.
// A read steps through tag lookup, write-back of a dirty victim line and
// fill of the missing line, both byte by byte over the byte-wide memory port
// and shared byte counter, then the byte access and the result hand-off; a
// hit skips write-back and fill, a clean miss skips write-back, and a write
// skips the hand-off. One access is in flight at a time; the next is taken
// while a result waits in the rsp register, and a stalled receiver holds the
// block only when a second read result is ready.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache
   import dmwbc_pkg::*;
#(
   parameter int LINE_BYTES   = 8,
   parameter int LINE_COUNT   = 32,
   parameter int MEMORY_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // address[15:0], write_data[23:16]
   input  logic        req_tuser,   // kind[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // read_data[7:0], hit[8], was_dirty[9], zero[15:10]
);

   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int LINE_W = $clog2(LINE_COUNT);
   localparam int CA_W   = OFF_W + LINE_W;
   localparam int MEM_W  = $clog2(MEMORY_BYTES);

   ctl_type            ctl;
   logic [CA_W-1:0]    cache_addr;
   logic [DATA_W-1:0]  cache_wdata;
   logic [DATA_W-1:0]  cache_rdata;
   logic [MEM_W-1:0]   main_addr;
   logic [DATA_W-1:0]  mem_wdata;
   logic [DATA_W-1:0]  mem_rdata;
   logic               rd_hit;
   logic               rd_dirty;
   logic               out_free;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_hit_ff;
   logic               rsp_dirty_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   dmwbc_seq #(
      .LINE_BYTES   (LINE_BYTES),
      .LINE_COUNT   (LINE_COUNT),
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_address (req_tdata[ADDR_W-1:0]),
      .req_wdata   (req_tdata[ADDR_W +: DATA_W]),
      .out_free    (out_free),
      .cache_rdata (cache_rdata),
      .mem_rdata   (mem_rdata),
      .ctl         (ctl),
      .cache_addr  (cache_addr),
      .cache_wdata (cache_wdata),
      .main_addr   (main_addr),
      .mem_wdata   (mem_wdata),
      .rd_hit      (rd_hit),
      .rd_dirty    (rd_dirty)
   );

   dmwbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LINE_COUNT * LINE_BYTES)
   ) u_cache_ram (
      .clock (clock),
      .we    (ctl.cache_we),
      .addr  (cache_addr),
      .wdata (cache_wdata),
      .rdata (cache_rdata)
   );

   dmwbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEMORY_BYTES)
   ) u_main_ram (
      .clock (clock),
      .we    (ctl.mem_we),
      .addr  (main_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_data_ff  <= cache_rdata;
         rsp_hit_ff   <= rd_hit;
         rsp_dirty_ff <= rd_dirty;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_dirty_ff, rsp_hit_ff, rsp_data_ff};

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (ctl.state == ST_CLEAR) |-> !rsp_tvalid)
      else $error("result word during clearing pass");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word accepted while an access is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result word overwritten");

   a_mem_write_phase: assert property (@(posedge clock) disable iff (reset)
      ctl.mem_we |-> (ctl.state == ST_CLEAR || ctl.state == ST_WB))
      else $error("memory written outside clear or write-back");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for direct_mapped_writeback_cache. A shadow copy of
// tags, dirty marks, line bytes and main memory predicts each read word;
// the bench runs directed corner accesses, then random traffic over a small
// set of tags and lines under changing req/rsp idling and one long rsp stall.
// ----------------------------------------------------------------------------
module tb_top
   import dmwbc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_BYTES   = 8;
   localparam int LINE_COUNT   = 32;
   localparam int MEMORY_BYTES = 65536;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [7:0] data;
      logic       hit;
      logic       was_dirty;
   } read_word_type;

   class cache_shadow;
      bit [7:0]      tags [LINE_COUNT];
      bit            dirty [LINE_COUNT];
      bit [7:0]      bytes [LINE_COUNT][LINE_BYTES];
      bit [7:0]      memory [MEMORY_BYTES];
      read_word_type expected_reads [$];
      int            errors;
      int            reads;
      int            writes;
      int            hits;
      int            writebacks;

      function void note_access(logic kind, logic [15:0] address, logic [7:0] wdata);
         bit [2:0]      offset;
         bit [4:0]      line;
         bit [7:0]      tag;
         bit            hit;
         bit            was_dirty;
         read_word_type word;
         offset    = address[2:0];
         line      = address[7:3];
         tag       = address[15:8];
         was_dirty = dirty[line];
         hit       = (tags[line] == tag);
         if (hit) begin
            hits++;
         end else begin
            if (was_dirty) begin
               writebacks++;
               for (int i = 0; i < LINE_BYTES; i++)
                  memory[{tags[line], line, 3'(i)}] = bytes[line][i];
            end
            tags[line]  = tag;
            dirty[line] = 1'b0;
            for (int i = 0; i < LINE_BYTES; i++)
               bytes[line][i] = memory[{tag, line, 3'(i)}];
         end
         if (kind == KIND_WRITE) begin
            writes++;
            bytes[line][offset] = wdata;
            dirty[line] = 1'b1;
         end else begin
            reads++;
            word.data      = bytes[line][offset];
            word.hit       = hit;
            word.was_dirty = was_dirty;
            expected_reads.push_back(word);
         end
      endfunction

      function void check_result(logic [15:0] tdata);
         read_word_type want;
         if (expected_reads.size() == 0) begin
            $display("%0t: unexpected read word %04h", $time, tdata);
            errors++;
            return;
         end
         want = expected_reads.pop_front();
         if (tdata[7:0] !== want.data) begin
            $display("%0t: read_data expected %02h actual %02h", $time, want.data, tdata[7:0]);
            errors++;
         end
         if (tdata[8] !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, tdata[8]);
            errors++;
         end
         if (tdata[9] !== want.was_dirty) begin
            $display("%0t: was_dirty expected %0b actual %0b", $time, want.was_dirty,
                     tdata[9]);
            errors++;
         end
         if (tdata[15:10] !== 6'd0) begin
            $display("%0t: pad bits expected 00 actual %02h", $time, tdata[15:10]);
            errors++;
         end
      endfunction

      function int pending();
         return expected_reads.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // address[15:0], write_data[23:16]
   logic        req_tuser  = 1'b0; // kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // read_data[7:0], hit[8], was_dirty[9], zero[15:10]

   cache_shadow shadow       = new();
   int          cycles       = 0;
   int          send_idle    = 0;
   int          recv_idle    = 0;
   int          holdoff_left = 0;
   logic [7:0]  tag_pool [4];

   direct_mapped_writeback_cache #(
      .LINE_BYTES  (LINE_BYTES),
      .LINE_COUNT  (LINE_COUNT),
      .MEMORY_BYTES(MEMORY_BYTES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_tready <= 1'b0;
         holdoff_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         shadow.check_result(rsp_tdata);
   end

   // call at a rising edge; returns at the rising edge that takes the word
   task automatic send_access(input logic kind, input logic [15:0] address,
                              input logic [7:0] wdata);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {wdata, address};
      do @(posedge clock); while (!req_tready);
      shadow.note_access(kind, address, wdata);
   endtask

   function automatic logic [15:0] pick_address();
      logic [7:0] tag;
      logic [4:0] line;
      if ($urandom_range(9) < 8)
         tag = tag_pool[$urandom_range(3)];
      else
         tag = 8'($urandom);
      if ($urandom_range(1) == 0)
         line = 5'($urandom_range(7));
      else
         line = 5'($urandom);
      return {tag, line, 3'($urandom)};
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < 4; i++)
         tag_pool[i] = 8'($urandom);
      repeat (count) begin
         send_access($urandom_range(1) ? KIND_WRITE : KIND_READ, pick_address(),
                     8'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_access(KIND_READ,  16'h0000, 8'h00);
      send_access(KIND_READ,  16'hFFFF, 8'hFF);
      send_access(KIND_WRITE, 16'hFFFF, 8'hFF);
      send_access(KIND_READ,  16'hFFFF, 8'h00);
      send_access(KIND_WRITE, 16'h0000, 8'hA5);
      send_access(KIND_READ,  16'h0000, 8'h00);
      send_access(KIND_READ,  16'h0007, 8'h00);
      send_access(KIND_READ,  16'h00FF, 8'h00);
      send_access(KIND_READ,  16'hFFFF, 8'h00);
      send_access(KIND_WRITE, 16'h1234, 8'h5A);
      send_access(KIND_READ,  16'h1234, 8'h00);
      send_access(KIND_WRITE, 16'hAB34, 8'h00);
      send_access(KIND_READ,  16'h1234, 8'hFF);
      send_access(KIND_READ,  16'hAB34, 8'h00);
      send_access(KIND_WRITE, 16'h5555, 8'h55);
      send_access(KIND_WRITE, 16'hAAAA, 8'hAA);
      send_access(KIND_READ,  16'h5555, 8'h00);
      send_access(KIND_READ,  16'hAAAA, 8'h00);
      send_access(KIND_WRITE, 16'h00F8, 8'h3C);
      send_access(KIND_READ,  16'hFFF8, 8'h00);
      send_access(KIND_READ,  16'h00F8, 8'h00);

      send_idle = 6;
      recv_idle = 49;
      run_random(610);

      send_idle = 49;
      recv_idle = 6;
      run_random(610);

      send_idle = 0;
      recv_idle = 0;
      for (int i = 0; i < 4; i++)
         tag_pool[i] = 8'($urandom);
      holdoff_left = 400;
      repeat (40) send_access(KIND_READ, pick_address(), 8'($urandom));
      run_random(570);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("accesses: %0d reads, %0d writes, %0d hits, %0d write-backs",
               shadow.reads, shadow.writes, shadow.hits, shadow.writebacks);
      $display("covered corner addresses, three idling mixes and a 400-cycle rsp stall");
      if (shadow.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
